@@ src/avr_pkg.sv @@
// shared constants, types and tables for the axis vector rotator
package avr_pkg;

    localparam int COORD_WIDTH_DEF   = 32;
    localparam int CORDIC_STAGES_DEF = 24;

    localparam int OP_W       = 2;
    localparam int ANGLE_W    = 32;
    localparam int CQ_W       = 34;
    localparam int TRIG_MAG_W = 31;
    localparam int FRAC_W     = 30;

    typedef logic [OP_W-1:0] op_t;

    localparam op_t OP_ROT_X = 2'd0;
    localparam op_t OP_ROT_Y = 2'd1;
    localparam op_t OP_ROT_Z = 2'd2;

    typedef logic signed [ANGLE_W-1:0] angle_t;
    typedef logic signed [CQ_W-1:0]    cq_t;

    localparam angle_t PI_Q28      = 32'sd843314857;
    localparam angle_t TWO_PI_Q28  = 32'sd1686629713;
    localparam angle_t HALF_PI_Q28 = 32'sd421657428;
    localparam cq_t    GAIN_Q30    = 34'sd652032874;

    typedef struct packed {
        logic valid;
        op_t  op;
        logic flip;
    } ctl_t;

    // arctangent of 2^-idx, q4.30, truncated
    function automatic cq_t atan_q30(input int idx);
        cq_t t;
        case (idx)
            0:       t = 34'sd843314856;
            1:       t = 34'sd497837829;
            2:       t = 34'sd263043836;
            3:       t = 34'sd133525158;
            4:       t = 34'sd67021686;
            5:       t = 34'sd33543515;
            6:       t = 34'sd16775850;
            7:       t = 34'sd8388437;
            8:       t = 34'sd4194282;
            9:       t = 34'sd2097149;
            10:      t = 34'sd1048575;
            11:      t = 34'sd524287;
            12:      t = 34'sd262143;
            13:      t = 34'sd131071;
            14:      t = 34'sd65535;
            15:      t = 34'sd32767;
            16:      t = 34'sd16383;
            17:      t = 34'sd8191;
            18:      t = 34'sd4095;
            19:      t = 34'sd2047;
            20:      t = 34'sd1023;
            21:      t = 34'sd511;
            22:      t = 34'sd255;
            23:      t = 34'sd127;
            24:      t = 34'sd63;
            25:      t = 34'sd31;
            26:      t = 34'sd15;
            27:      t = 34'sd7;
            28:      t = 34'sd3;
            29:      t = 34'sd1;
            default: t = '0;
        endcase
        return t;
    endfunction

endpackage

@@ src/axis_vector_rotate.sv @@
// top level: stream rotator of a 3d vector about one coordinate axis
// Takes one transfer per clock while s_axis_tready is high and returns one result per transfer,
// in order. The pipeline is the angle wrap and fold registers, one cordic cell per stage, the
// magnitude, product and rounded-product registers of the mix, and the output register. The
// pipeline moves as one; a two-entry output (register plus skid) keeps s_axis_tready high
// while one finished result waits, and the pipeline holds only once both entries are full.
// Axis code 3 passes the vector through with saturated low.
module axis_vector_rotate #(
    parameter int COORD_WIDTH   = avr_pkg::COORD_WIDTH_DEF,
    parameter int CORDIC_STAGES = avr_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                                  clk,
    input  logic                                                  rst_n,
    input  logic                                                  s_axis_tvalid,
    output logic                                                  s_axis_tready,
    // angle, x_in, y_in, z_in
    input  logic [((avr_pkg::ANGLE_W + 3 * COORD_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // operation
    input  avr_pkg::op_t                                          s_axis_tuser,
    output logic                                                  m_axis_tvalid,
    input  logic                                                  m_axis_tready,
    // x_out, y_out, z_out
    output logic [((3 * COORD_WIDTH + 7) / 8) * 8 - 1:0]          m_axis_tdata,
    // saturated
    output logic                                                  m_axis_tuser
);
    import avr_pkg::*;

    localparam int W          = COORD_WIDTH;
    localparam int OUT_DATA_W = ((3 * W + 7) / 8) * 8;
    localparam int WORD_W     = 3 * W;

    typedef logic signed [W-1:0] coord_t;

    logic   en;
    ctl_t   ctl_s;

    ctl_t   ctl_c [CORDIC_STAGES+1];
    coord_t vx_c  [CORDIC_STAGES+1];
    coord_t vy_c  [CORDIC_STAGES+1];
    coord_t vz_c  [CORDIC_STAGES+1];
    cq_t    cx_c  [CORDIC_STAGES+1];
    cq_t    cy_c  [CORDIC_STAGES+1];
    cq_t    cz_c  [CORDIC_STAGES+1];

    logic   res_valid;
    coord_t x_res;
    coord_t y_res;
    coord_t z_res;
    logic   sat_res;

    logic              out_valid_reg;
    logic [WORD_W-1:0] out_word_reg;
    logic              out_sat_reg;
    logic              skid_valid_reg;
    logic [WORD_W-1:0] skid_word_reg;
    logic              skid_sat_reg;
    logic [WORD_W-1:0] res_word;

    assign en            = !skid_valid_reg;
    assign s_axis_tready = !skid_valid_reg;

    always_comb
    begin
        ctl_s.valid = s_axis_tvalid & s_axis_tready;
        ctl_s.op    = s_axis_tuser;
        ctl_s.flip  = 1'b0;
    end

    avr_reduce #(
        .COORD_WIDTH (W)
    ) u_reduce (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .ctl_in   (ctl_s),
        .angle_in (s_axis_tdata[ANGLE_W-1:0]),
        .vx_in    (s_axis_tdata[ANGLE_W+W-1:ANGLE_W]),
        .vy_in    (s_axis_tdata[ANGLE_W+2*W-1:ANGLE_W+W]),
        .vz_in    (s_axis_tdata[ANGLE_W+3*W-1:ANGLE_W+2*W]),
        .ctl_out  (ctl_c[0]),
        .vx_out   (vx_c[0]),
        .vy_out   (vy_c[0]),
        .vz_out   (vz_c[0]),
        .cz_out   (cz_c[0])
    );

    assign cx_c[0] = GAIN_Q30;
    assign cy_c[0] = '0;

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cell
        avr_cell #(
            .COORD_WIDTH (W),
            .STAGE       (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .ctl_in  (ctl_c[i]),
            .vx_in   (vx_c[i]),
            .vy_in   (vy_c[i]),
            .vz_in   (vz_c[i]),
            .cx_in   (cx_c[i]),
            .cy_in   (cy_c[i]),
            .cz_in   (cz_c[i]),
            .ctl_out (ctl_c[i+1]),
            .vx_out  (vx_c[i+1]),
            .vy_out  (vy_c[i+1]),
            .vz_out  (vz_c[i+1]),
            .cx_out  (cx_c[i+1]),
            .cy_out  (cy_c[i+1]),
            .cz_out  (cz_c[i+1])
        );
    end

    avr_mix #(
        .COORD_WIDTH (W)
    ) u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .ctl_in    (ctl_c[CORDIC_STAGES]),
        .vx_in     (vx_c[CORDIC_STAGES]),
        .vy_in     (vy_c[CORDIC_STAGES]),
        .vz_in     (vz_c[CORDIC_STAGES]),
        .cos_in    (cx_c[CORDIC_STAGES]),
        .sin_in    (cy_c[CORDIC_STAGES]),
        .res_valid (res_valid),
        .x_res     (x_res),
        .y_res     (y_res),
        .z_res     (z_res),
        .sat_res   (sat_res)
    );

    assign res_word = {z_res, y_res, x_res};

    // output register with one skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (m_axis_tready)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (res_valid)
        begin
            if (out_valid_reg && !m_axis_tready)
            begin
                skid_valid_reg <= 1'b1;
            end
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (m_axis_tready)
            begin
                out_word_reg <= skid_word_reg;
                out_sat_reg  <= skid_sat_reg;
            end
        end
        else if (res_valid)
        begin
            if (out_valid_reg && !m_axis_tready)
            begin
                skid_word_reg <= res_word;
                skid_sat_reg  <= sat_res;
            end
            else
            begin
                out_word_reg <= res_word;
                out_sat_reg  <= sat_res;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'(out_word_reg);
    assign m_axis_tuser  = out_sat_reg;

endmodule

@@ src/avr_reduce.sv @@
// two-stage angle range reduction into q4.30 with quadrant fold
module avr_reduce #(
    parameter int COORD_WIDTH = avr_pkg::COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  avr_pkg::ctl_t                 ctl_in,
    input  avr_pkg::angle_t               angle_in,
    input  logic signed [COORD_WIDTH-1:0] vx_in,
    input  logic signed [COORD_WIDTH-1:0] vy_in,
    input  logic signed [COORD_WIDTH-1:0] vz_in,
    output avr_pkg::ctl_t                 ctl_out,
    output logic signed [COORD_WIDTH-1:0] vx_out,
    output logic signed [COORD_WIDTH-1:0] vy_out,
    output logic signed [COORD_WIDTH-1:0] vz_out,
    output avr_pkg::cq_t                  cz_out
);
    import avr_pkg::*;

    ctl_t                          ctl1_reg;
    angle_t                        wrap_reg;
    angle_t                        wrap_next;
    logic signed [COORD_WIDTH-1:0] vx1_reg;
    logic signed [COORD_WIDTH-1:0] vy1_reg;
    logic signed [COORD_WIDTH-1:0] vz1_reg;

    ctl_t                          ctl2_reg;
    ctl_t                          ctl2_next;
    angle_t                        fold;
    cq_t                           cz_reg;
    cq_t                           cz_next;
    logic signed [COORD_WIDTH-1:0] vx2_reg;
    logic signed [COORD_WIDTH-1:0] vy2_reg;
    logic signed [COORD_WIDTH-1:0] vz2_reg;

    // one wrap by 2*pi covers the whole q4.28 range
    always_comb
    begin
        if (angle_in > PI_Q28)
        begin
            wrap_next = angle_in - TWO_PI_Q28;
        end
        else if (angle_in < -PI_Q28)
        begin
            wrap_next = angle_in + TWO_PI_Q28;
        end
        else
        begin
            wrap_next = angle_in;
        end
    end

    // fold outer quadrants into [-pi/2, pi/2], flip sign of sin and cos
    always_comb
    begin
        ctl2_next = ctl1_reg;
        if (wrap_reg > HALF_PI_Q28)
        begin
            fold           = wrap_reg - PI_Q28;
            ctl2_next.flip = 1'b1;
        end
        else if (wrap_reg < -HALF_PI_Q28)
        begin
            fold           = wrap_reg + PI_Q28;
            ctl2_next.flip = 1'b1;
        end
        else
        begin
            fold           = wrap_reg;
            ctl2_next.flip = 1'b0;
        end
        cz_next = cq_t'(fold) <<< 2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end
        else if (en)
        begin
            ctl1_reg <= ctl_in;
            ctl2_reg <= ctl2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wrap_reg <= wrap_next;
            vx1_reg  <= vx_in;
            vy1_reg  <= vy_in;
            vz1_reg  <= vz_in;
            cz_reg   <= cz_next;
            vx2_reg  <= vx1_reg;
            vy2_reg  <= vy1_reg;
            vz2_reg  <= vz1_reg;
        end
    end

    assign ctl_out = ctl2_reg;
    assign vx_out  = vx2_reg;
    assign vy_out  = vy2_reg;
    assign vz_out  = vz2_reg;
    assign cz_out  = cz_reg;

endmodule

@@ src/avr_cell.sv @@
// one cordic rotation cell of the chain, carries the vector alongside
module avr_cell #(
    parameter int COORD_WIDTH = avr_pkg::COORD_WIDTH_DEF,
    parameter int STAGE       = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  avr_pkg::ctl_t                 ctl_in,
    input  logic signed [COORD_WIDTH-1:0] vx_in,
    input  logic signed [COORD_WIDTH-1:0] vy_in,
    input  logic signed [COORD_WIDTH-1:0] vz_in,
    input  avr_pkg::cq_t                  cx_in,
    input  avr_pkg::cq_t                  cy_in,
    input  avr_pkg::cq_t                  cz_in,
    output avr_pkg::ctl_t                 ctl_out,
    output logic signed [COORD_WIDTH-1:0] vx_out,
    output logic signed [COORD_WIDTH-1:0] vy_out,
    output logic signed [COORD_WIDTH-1:0] vz_out,
    output avr_pkg::cq_t                  cx_out,
    output avr_pkg::cq_t                  cy_out,
    output avr_pkg::cq_t                  cz_out
);
    import avr_pkg::*;

    localparam cq_t ATAN = atan_q30(STAGE);

    ctl_t                          ctl_reg;
    logic signed [COORD_WIDTH-1:0] vx_reg;
    logic signed [COORD_WIDTH-1:0] vy_reg;
    logic signed [COORD_WIDTH-1:0] vz_reg;
    cq_t                           cx_reg;
    cq_t                           cy_reg;
    cq_t                           cz_reg;
    cq_t                           cx_next;
    cq_t                           cy_next;
    cq_t                           cz_next;
    cq_t                           dx;
    cq_t                           dy;

    always_comb
    begin
        dx = cy_in >>> STAGE;
        dy = cx_in >>> STAGE;
        if (!cz_in[CQ_W-1])
        begin
            cx_next = cx_in - dx;
            cy_next = cy_in + dy;
            cz_next = cz_in - ATAN;
        end
        else
        begin
            cx_next = cx_in + dx;
            cy_next = cy_in - dy;
            cz_next = cz_in + ATAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vx_reg <= vx_in;
            vy_reg <= vy_in;
            vz_reg <= vz_in;
            cx_reg <= cx_next;
            cy_reg <= cy_next;
            cz_reg <= cz_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign vx_out  = vx_reg;
    assign vy_out  = vy_reg;
    assign vz_out  = vz_reg;
    assign cx_out  = cx_reg;
    assign cy_out  = cy_reg;
    assign cz_out  = cz_reg;

endmodule

@@ src/avr_mix.sv @@
// products with sin and cos, rounding, sum and saturation of the two moved components
module avr_mix #(
    parameter int COORD_WIDTH = avr_pkg::COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  avr_pkg::ctl_t                 ctl_in,
    input  logic signed [COORD_WIDTH-1:0] vx_in,
    input  logic signed [COORD_WIDTH-1:0] vy_in,
    input  logic signed [COORD_WIDTH-1:0] vz_in,
    input  avr_pkg::cq_t                  cos_in,
    input  avr_pkg::cq_t                  sin_in,
    output logic                          res_valid,
    output logic signed [COORD_WIDTH-1:0] x_res,
    output logic signed [COORD_WIDTH-1:0] y_res,
    output logic signed [COORD_WIDTH-1:0] z_res,
    output logic                          sat_res
);
    import avr_pkg::*;

    localparam int W      = COORD_WIDTH;
    localparam int LO_W   = (W + 1) / 2;
    localparam int HI_W   = W - LO_W;
    localparam int PHI_W  = HI_W + TRIG_MAG_W;
    localparam int PLO_W  = LO_W + TRIG_MAG_W;
    localparam int PROD_W = W + TRIG_MAG_W;
    localparam int RND_W  = PROD_W - FRAC_W;
    localparam int SGN_W  = RND_W + 1;
    localparam int SUM_W  = SGN_W + 1;

    typedef logic [W-1:0]              mag_t;
    typedef logic [TRIG_MAG_W-1:0]     tmag_t;
    typedef logic signed [W-1:0]       coord_t;
    typedef logic signed [SGN_W-1:0]   rnd_t;
    typedef logic signed [SUM_W-1:0]   sum_t;

    function automatic mag_t coord_mag(input coord_t v);
        mag_t u;
        u = v;
        return u[W-1] ? (~u + 1'b1) : u;
    endfunction

    function automatic tmag_t trig_mag(input cq_t v);
        cq_t u;
        u = v[CQ_W-1] ? -v : v;
        return u[TRIG_MAG_W-1:0];
    endfunction

    // exact magnitude product, rounded half away from zero, then signed
    function automatic rnd_t round_q30(input logic [PHI_W-1:0] hi,
                                       input logic [PLO_W-1:0] lo,
                                       input logic neg);
        logic [PROD_W-1:0] m;
        logic [RND_W-1:0]  r;
        rnd_t              sr;
        m  = {hi, {LO_W{1'b0}}} + PROD_W'(lo) + (PROD_W'(1) << (FRAC_W - 1));
        r  = m[PROD_W-1:FRAC_W];
        sr = $signed({1'b0, r});
        return neg ? -sr : sr;
    endfunction

    function automatic logic ovf(input sum_t v);
        return v[SUM_W-1:W-1] != {(SUM_W-W+1){v[SUM_W-1]}};
    endfunction

    function automatic coord_t clip(input sum_t v);
        coord_t c;
        if (!ovf(v))
        begin
            c = v[W-1:0];
        end
        else if (v[SUM_W-1])
        begin
            c = {1'b1, {(W-1){1'b0}}};
        end
        else
        begin
            c = {1'b0, {(W-1){1'b1}}};
        end
        return c;
    endfunction

    // operand select: a = p*cos - q*sin, b = p*sin + q*cos
    coord_t p;
    coord_t q;

    ctl_t   ctl0_reg;
    coord_t vx0_reg;
    coord_t vy0_reg;
    coord_t vz0_reg;
    mag_t   pm0_reg;
    mag_t   qm0_reg;
    logic   pn0_reg;
    logic   qn0_reg;
    tmag_t  cm0_reg;
    tmag_t  sm0_reg;
    logic   cn0_reg;
    logic   sn0_reg;

    ctl_t              ctl1_reg;
    coord_t            vx1_reg;
    coord_t            vy1_reg;
    coord_t            vz1_reg;
    logic [PHI_W-1:0]  pc_hi_reg;
    logic [PLO_W-1:0]  pc_lo_reg;
    logic [PHI_W-1:0]  qs_hi_reg;
    logic [PLO_W-1:0]  qs_lo_reg;
    logic [PHI_W-1:0]  ps_hi_reg;
    logic [PLO_W-1:0]  ps_lo_reg;
    logic [PHI_W-1:0]  qc_hi_reg;
    logic [PLO_W-1:0]  qc_lo_reg;
    logic              pcn1_reg;
    logic              qsn1_reg;
    logic              psn1_reg;
    logic              qcn1_reg;

    ctl_t   ctl2_reg;
    coord_t vx2_reg;
    coord_t vy2_reg;
    coord_t vz2_reg;
    rnd_t   pc2_reg;
    rnd_t   qs2_reg;
    rnd_t   ps2_reg;
    rnd_t   qc2_reg;

    sum_t   sum_a;
    sum_t   sum_b;
    coord_t ca;
    coord_t cb;
    logic   any_ovf;

    always_comb
    begin
        unique case (ctl_in.op)
            OP_ROT_X:
            begin
                p = vy_in;
                q = vz_in;
            end
            OP_ROT_Y:
            begin
                p = vz_in;
                q = vx_in;
            end
            default:
            begin
                p = vx_in;
                q = vy_in;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl0_reg <= '0;
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end
        else if (en)
        begin
            ctl0_reg <= ctl_in;
            ctl1_reg <= ctl0_reg;
            ctl2_reg <= ctl1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vx0_reg   <= vx_in;
            vy0_reg   <= vy_in;
            vz0_reg   <= vz_in;
            pm0_reg   <= coord_mag(p);
            qm0_reg   <= coord_mag(q);
            pn0_reg   <= p[W-1];
            qn0_reg   <= q[W-1];
            cm0_reg   <= trig_mag(cos_in);
            sm0_reg   <= trig_mag(sin_in);
            cn0_reg   <= cos_in[CQ_W-1] ^ ctl_in.flip;
            sn0_reg   <= sin_in[CQ_W-1] ^ ctl_in.flip;

            vx1_reg   <= vx0_reg;
            vy1_reg   <= vy0_reg;
            vz1_reg   <= vz0_reg;
            pc_hi_reg <= pm0_reg[W-1:LO_W] * cm0_reg;
            pc_lo_reg <= pm0_reg[LO_W-1:0] * cm0_reg;
            qs_hi_reg <= qm0_reg[W-1:LO_W] * sm0_reg;
            qs_lo_reg <= qm0_reg[LO_W-1:0] * sm0_reg;
            ps_hi_reg <= pm0_reg[W-1:LO_W] * sm0_reg;
            ps_lo_reg <= pm0_reg[LO_W-1:0] * sm0_reg;
            qc_hi_reg <= qm0_reg[W-1:LO_W] * cm0_reg;
            qc_lo_reg <= qm0_reg[LO_W-1:0] * cm0_reg;
            pcn1_reg  <= pn0_reg ^ cn0_reg;
            qsn1_reg  <= qn0_reg ^ sn0_reg;
            psn1_reg  <= pn0_reg ^ sn0_reg;
            qcn1_reg  <= qn0_reg ^ cn0_reg;

            vx2_reg   <= vx1_reg;
            vy2_reg   <= vy1_reg;
            vz2_reg   <= vz1_reg;
            pc2_reg   <= round_q30(pc_hi_reg, pc_lo_reg, pcn1_reg);
            qs2_reg   <= round_q30(qs_hi_reg, qs_lo_reg, qsn1_reg);
            ps2_reg   <= round_q30(ps_hi_reg, ps_lo_reg, psn1_reg);
            qc2_reg   <= round_q30(qc_hi_reg, qc_lo_reg, qcn1_reg);
        end
    end

    always_comb
    begin
        sum_a   = pc2_reg - qs2_reg;
        sum_b   = ps2_reg + qc2_reg;
        ca      = clip(sum_a);
        cb      = clip(sum_b);
        any_ovf = ovf(sum_a) | ovf(sum_b);
        x_res   = vx2_reg;
        y_res   = vy2_reg;
        z_res   = vz2_reg;
        sat_res = 1'b0;
        unique case (ctl2_reg.op)
            OP_ROT_X:
            begin
                y_res   = ca;
                z_res   = cb;
                sat_res = any_ovf;
            end
            OP_ROT_Y:
            begin
                z_res   = ca;
                x_res   = cb;
                sat_res = any_ovf;
            end
            OP_ROT_Z:
            begin
                x_res   = ca;
                y_res   = cb;
                sat_res = any_ovf;
            end
            default:
            begin
                sat_res = 1'b0;
            end
        endcase
    end

    assign res_valid = ctl2_reg.valid;

endmodule

@@ src/avr_checker.sv @@
// port-level checks for the axis vector rotator and their bind
module avr_checker #(
    parameter int DATA_W = 96
) (
    input logic              clk,
    input logic              rst_n,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [DATA_W-1:0] m_axis_tdata,
    input logic              m_axis_tuser
);

    // a result offered is held until the transfer
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("m_axis_tvalid dropped without a transfer");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("m_axis payload changed while stalled");

    // input stalls only while a finished result is waiting
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("s_axis_tready low with no result waiting");

    // an output transfer always frees room for the next input
    a_free_after_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready |=> s_axis_tready)
        else $error("s_axis_tready low after an output transfer");

endmodule

bind axis_vector_rotate avr_checker #(
    .DATA_W (OUT_DATA_W)
) u_avr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

@@ bench/tb.sv @@
// self-checking testbench for the axis vector rotator, with its own fixed-point predictor
`timescale 1ns / 100ps

module tb;

    import avr_pkg::*;

    localparam int   CW          = COORD_WIDTH_DEF;
    localparam int   STAGES      = CORDIC_STAGES_DEF;
    localparam int   LATENCY     = STAGES + 6;
    localparam int   RANDOM_ITEMS = 1630;
    localparam int   STALL_LIMIT = 5000;
    localparam op_t  OP_PASS     = 2'd3;
    localparam longint COORD_MAX = (64'sd1 <<< (CW - 1)) - 1;
    localparam longint COORD_MIN = -(64'sd1 <<< (CW - 1));
    localparam longint PI_L      = longint'(PI_Q28);
    localparam longint TWO_PI_L  = longint'(TWO_PI_Q28);
    localparam longint HALF_PI_L = longint'(HALF_PI_Q28);
    localparam longint GAIN_L    = longint'(GAIN_Q30);

    typedef struct {
        op_t                   op;
        logic signed [31:0]    angle;
        logic signed [CW-1:0]  x;
        logic signed [CW-1:0]  y;
        logic signed [CW-1:0]  z;
    } rot_req_t;

    typedef struct {
        logic signed [CW-1:0]  x;
        logic signed [CW-1:0]  y;
        logic signed [CW-1:0]  z;
        logic                  sat;
    } rot_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [((ANGLE_W + 3 * CW + 7) / 8) * 8 - 1:0] s_data = '0;
    op_t  s_user = OP_ROT_X;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [((3 * CW + 7) / 8) * 8 - 1:0] m_data;
    logic m_user;

    rot_req_t vector_q [$];
    rot_res_t rotated_q [$];
    rot_req_t cur_vec;
    rot_res_t pred;
    rot_res_t seen, want;

    int errors = 0;
    int sent_cnt = 0;
    int got_cnt = 0;
    int sat_cnt = 0;
    int total_items = 0;
    int axis_cnt [4] = '{0, 0, 0, 0};
    int quiet_cycles = 0;

    always #5 clk = ~clk;

    axis_vector_rotate dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .s_axis_tuser  (s_user),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .m_axis_tuser  (m_user)
    );

    function automatic longint arctan_q30(input int k);
        case (k)
            0:       return 843314856;
            1:       return 497837829;
            2:       return 263043836;
            3:       return 133525158;
            4:       return 67021686;
            5:       return 33543515;
            6:       return 16775850;
            7:       return 8388437;
            8:       return 4194282;
            9:       return 2097149;
            10:      return 1048575;
            11:      return 524287;
            12:      return 262143;
            13:      return 131071;
            14:      return 65535;
            15:      return 32767;
            16:      return 16383;
            17:      return 8191;
            18:      return 4095;
            19:      return 2047;
            20:      return 1023;
            21:      return 511;
            22:      return 255;
            23:      return 127;
            24:      return 63;
            25:      return 31;
            26:      return 15;
            27:      return 7;
            28:      return 3;
            29:      return 1;
            default: return 0;
        endcase
    endfunction

    task automatic trig_of(input longint ang, output longint c, output longint s);
        longint a, cx, sy, za, dx, dy;
        bit flip;
        a = ang;
        flip = 1'b0;
        while (a > PI_L) a -= TWO_PI_L;
        while (a < -PI_L) a += TWO_PI_L;
        if (a > HALF_PI_L)
        begin
            a -= PI_L;
            flip = 1'b1;
        end
        else if (a < -HALF_PI_L)
        begin
            a += PI_L;
            flip = 1'b1;
        end
        za = a * 4;
        cx = GAIN_L;
        sy = 0;
        for (int i = 0; i < STAGES && i < 32; i++)
        begin
            dx = sy >>> i;
            dy = cx >>> i;
            if (za >= 0)
            begin
                cx -= dx;
                sy += dy;
                za -= arctan_q30(i);
            end
            else
            begin
                cx += dx;
                sy -= dy;
                za += arctan_q30(i);
            end
        end
        c = flip ? -cx : cx;
        s = flip ? -sy : sy;
    endtask

    // coordinate times q1.30 trig, rounded half away from zero
    function automatic longint scale_q30(input longint a, input longint t);
        longint unsigned ma, mt, q;
        bit neg;
        neg = (a < 0) != (t < 0);
        ma = (a < 0) ? -a : a;
        mt = (t < 0) ? -t : t;
        q = (ma * mt + (64'd1 << 29)) >> 30;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic bit clipped(input longint v);
        return (v > COORD_MAX) || (v < COORD_MIN);
    endfunction

    function automatic longint clamp_coord(input longint v);
        if (v > COORD_MAX) return COORD_MAX;
        if (v < COORD_MIN) return COORD_MIN;
        return v;
    endfunction

    task automatic rotate_expect(input rot_req_t r, output rot_res_t e);
        longint c, s, x, y, z, a, b;
        x = r.x;
        y = r.y;
        z = r.z;
        e.sat = 1'b0;
        if (r.op != OP_PASS)
        begin
            trig_of(longint'(r.angle), c, s);
            case (r.op)
                OP_ROT_X:
                begin
                    a = scale_q30(y, c) - scale_q30(z, s);
                    b = scale_q30(y, s) + scale_q30(z, c);
                    e.sat = clipped(a) | clipped(b);
                    y = clamp_coord(a);
                    z = clamp_coord(b);
                end
                OP_ROT_Y:
                begin
                    a = scale_q30(x, c) + scale_q30(z, s);
                    b = scale_q30(z, c) - scale_q30(x, s);
                    e.sat = clipped(a) | clipped(b);
                    x = clamp_coord(a);
                    z = clamp_coord(b);
                end
                default:
                begin
                    a = scale_q30(x, c) - scale_q30(y, s);
                    b = scale_q30(x, s) + scale_q30(y, c);
                    e.sat = clipped(a) | clipped(b);
                    x = clamp_coord(a);
                    y = clamp_coord(b);
                end
            endcase
        end
        e.x = x[CW-1:0];
        e.y = y[CW-1:0];
        e.z = z[CW-1:0];
    endtask

    task automatic note_mismatch(input string msg);
        $display("error at result %0d: %s", got_cnt, msg);
        errors++;
    endtask

    task automatic add_vector(input op_t op, input longint ang, input longint x,
                              input longint y, input longint z);
        rot_req_t r;
        r.op = op;
        r.angle = ang[31:0];
        r.x = x[CW-1:0];
        r.y = y[CW-1:0];
        r.z = z[CW-1:0];
        vector_q.push_back(r);
    endtask

    function automatic longint rand_coord();
        int unsigned k;
        k = $urandom_range(0, 9);
        case (k)
            0, 1, 2, 3: return longint'($signed($urandom));
            4, 5, 6:    return longint'($signed($urandom) >>> $urandom_range(0, 24));
            7:          return COORD_MAX;
            8:          return COORD_MIN;
            default:    return longint'($urandom_range(0, 2)) - 1;
        endcase
    endfunction

    function automatic longint rand_angle();
        int unsigned k;
        longint base;
        k = $urandom_range(0, 9);
        case (k)
            0, 1, 2, 3, 4: return longint'($signed($urandom));
            5, 6, 7:
                return longint'($urandom_range(0, 32'(2 * TWO_PI_L))) - TWO_PI_L;
            8:
            begin
                case ($urandom_range(0, 5))
                    0:       base = HALF_PI_L;
                    1:       base = -HALF_PI_L;
                    2:       base = PI_L;
                    3:       base = -PI_L;
                    4:       base = TWO_PI_L;
                    default: base = -TWO_PI_L;
                endcase
                return base + longint'($urandom_range(0, 8)) - 4;
            end
            default: return longint'($urandom_range(0, 64)) - 32;
        endcase
    endfunction

    function automatic op_t rand_axis();
        int unsigned k;
        k = $urandom_range(0, 15);
        if (k == 15) return OP_PASS;
        if (k < 5) return OP_ROT_X;
        if (k < 10) return OP_ROT_Y;
        return OP_ROT_Z;
    endfunction

    // driver: one pending vector per transfer, prediction taken at acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid <= 1'b0;
        end
        else
        begin
            if (s_valid && s_ready)
            begin
                rotate_expect(cur_vec, pred);
                rotated_q.push_back(pred);
                axis_cnt[cur_vec.op] <= axis_cnt[cur_vec.op] + 1;
                sent_cnt <= sent_cnt + 1;
            end
            if (!s_valid || s_ready)
            begin
                if (vector_q.size() > 0 &&
                    ((sent_cnt >= 700 && sent_cnt < 1000) || $urandom_range(0, 99) >= 19))
                begin
                    cur_vec = vector_q.pop_front();
                    s_valid <= 1'b1;
                    s_user  <= cur_vec.op;
                    s_data  <= {cur_vec.z, cur_vec.y, cur_vec.x, cur_vec.angle};
                end
                else
                begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result transfer with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_ready <= 1'b0;
        end
        else
        begin
            if (m_valid && m_ready)
            begin
                seen.x   = m_data[CW-1:0];
                seen.y   = m_data[2*CW-1:CW];
                seen.z   = m_data[3*CW-1:2*CW];
                seen.sat = m_user;
                if (rotated_q.size() == 0)
                begin
                    note_mismatch("result with no prediction pending");
                end
                else
                begin
                    want = rotated_q.pop_front();
                    if (seen.x !== want.x)
                        note_mismatch($sformatf("x_out %0d, expected %0d", seen.x, want.x));
                    if (seen.y !== want.y)
                        note_mismatch($sformatf("y_out %0d, expected %0d", seen.y, want.y));
                    if (seen.z !== want.z)
                        note_mismatch($sformatf("z_out %0d, expected %0d", seen.z, want.z));
                    if (seen.sat !== want.sat)
                        note_mismatch($sformatf("saturated %b, expected %b",
                                                seen.sat, want.sat));
                    if (want.sat)
                        sat_cnt <= sat_cnt + 1;
                end
                got_cnt <= got_cnt + 1;
            end
            m_ready <= (got_cnt >= 700 && got_cnt < 1000) || ($urandom_range(0, 99) >= 19);
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("timeout after %0d cycles with no transfer", quiet_cycles);
                $display("axis_vector_rotate: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        // directed: axes, pass-through, angle extremes, quadrant edges, saturation
        add_vector(OP_ROT_X, 0, 65536, 131072, 196608);
        add_vector(OP_ROT_Y, 0, 65536, 131072, 196608);
        add_vector(OP_ROT_Z, 0, 65536, 131072, 196608);
        add_vector(OP_PASS, 2147483647, COORD_MAX, COORD_MIN, -1);
        add_vector(OP_PASS, 0, 0, 0, 0);
        add_vector(OP_ROT_X, HALF_PI_L, COORD_MAX, COORD_MAX, COORD_MAX);
        add_vector(OP_ROT_Y, -HALF_PI_L, COORD_MIN, COORD_MIN, COORD_MIN);
        add_vector(OP_ROT_Z, PI_L, COORD_MIN, COORD_MIN, 0);
        add_vector(OP_ROT_Z, -PI_L, COORD_MAX, 0, COORD_MIN);
        add_vector(OP_ROT_X, HALF_PI_L + 1, 1, COORD_MAX, -65536);
        add_vector(OP_ROT_Y, -HALF_PI_L - 1, COORD_MAX, 7, COORD_MIN);
        add_vector(OP_ROT_Z, 2147483647, 65536, -65536, 12345);
        add_vector(OP_ROT_X, -2147483648, -1, COORD_MAX, COORD_MIN);
        add_vector(OP_ROT_Y, TWO_PI_L, 327680, 0, -327680);
        add_vector(OP_ROT_Z, -TWO_PI_L, -327680, 98304, 0);
        add_vector(OP_ROT_Z, 210828714, COORD_MAX, COORD_MAX, 0);
        add_vector(OP_ROT_X, 210828714, 0, COORD_MIN, COORD_MIN);
        add_vector(OP_ROT_Y, -210828714, COORD_MIN, 0, COORD_MAX);
        add_vector(OP_ROT_Y, 1, 0, 0, 0);
        add_vector(OP_ROT_Z, -1, 1, -1, 1);
        add_vector(OP_ROT_X, PI_L + 1, 123456, -654321, 99999);
        add_vector(OP_ROT_Z, -PI_L - 1, -99999, 654321, -123456);
        for (int n = 0; n < RANDOM_ITEMS; n++)
            add_vector(rand_axis(), rand_angle(), rand_coord(), rand_coord(), rand_coord());
        total_items = vector_q.size();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (got_cnt < total_items) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (rotated_q.size() != 0)
            note_mismatch("predictions left without a result");

        $display("covered %0d vectors in, %0d results out, %0d saturated", sent_cnt,
                 got_cnt, sat_cnt);
        $display("axis mix: x %0d, y %0d, z %0d, pass-through %0d; %0d errors",
                 axis_cnt[OP_ROT_X], axis_cnt[OP_ROT_Y], axis_cnt[OP_ROT_Z],
                 axis_cnt[OP_PASS], errors);
        if (errors == 0)
            $display("axis_vector_rotate: match");
        else
            $display("axis_vector_rotate: mismatch");
        $finish;
    end

endmodule
